>>> src/dsdvs_pkg.sv
// ----------------------------------------------------------------------------
// dsdvs_pkg: shared types and constants for the DPCM sample decoder
// Item layouts, the lane-to-merge bundle, the gain request and the fixed
// constants of the decode and scaling path.
// ----------------------------------------------------------------------------
package dsdvs_pkg;

  // Number of entries in the delta table; a nibble selects one of them.
  localparam int DELTA_ENTRIES = 16;
  localparam int NIB_W         = $clog2(DELTA_ENTRIES);

  // Configuration register indexes.
  localparam int          CFG_IDX_W          = 3;
  localparam logic [2:0]  REG_CODING_MODE    = 3'd0;
  localparam logic [2:0]  REG_DELTA_LOW      = 3'd1;
  localparam logic [2:0]  REG_DELTA_HIGH     = 3'd2;
  localparam logic [2:0]  REG_VOLUME         = 3'd3;
  localparam logic [2:0]  REG_VOL_DIVISOR    = 3'd4;

  // Reset values and fixed constants. The reset gain is the one that the
  // reset volume and divisor give: (256*256 + 128) / 256.
  localparam logic [7:0]  ACC_INIT     = 8'h80;
  localparam logic [15:0] VOLUME_RESET = 16'h0100;
  localparam logic [15:0] DIV_RESET    = 16'h0100;
  localparam logic [31:0] GAIN_RESET   = 32'h0000_0100;
  localparam logic [31:0] GAIN_MAX     = 32'h7FFF_FFFF;

  // Restoring divider: numerator is volume*256 plus half the divisor.
  localparam int QUO_W    = 25;
  localparam int DIV_CNT_W = $clog2(QUO_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

  // Input item as it arrives on the input channel.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       sample_start;
    logic       end_of_sample;
  } in_item_t;

  // Result item as it leaves on the output channel.
  typedef struct packed {
    logic [7:0] sample_out;
    logic       last_of_run;
    logic       sample_end;
  } out_item_t;

  // Scaled samples of one item handed from the lanes to the merge stage.
  typedef struct packed {
    logic [7:0] sample0;
    logic [7:0] sample1;
    logic       two;
    logic       eos;
  } pair_t;

  // Request to derive a new gain from the register values after a write.
  typedef struct packed {
    logic        start;
    logic [15:0] volume;
    logic [15:0] divisor;
  } gain_req_t;

  // Gain unit status.
  typedef struct packed {
    logic        busy;
    logic [31:0] gain;
  } gain_sts_t;

endpackage

>>> src/dsdvs_gain.sv
// ----------------------------------------------------------------------------
// dsdvs_gain: gain factor derivation
// Derives the 32-bit gain from volume and divisor. A positive divisor runs a
// one-bit-per-cycle restoring divider with rounding; otherwise the volume is
// multiplied by the negated divisor and saturated.
// ----------------------------------------------------------------------------
module dsdvs_gain (
  input  logic                clk,
  input  logic                rst_n,
  input  dsdvs_pkg::gain_req_t req,
  output dsdvs_pkg::gain_sts_t sts
);
  import dsdvs_pkg::*;

  typedef enum logic [2:0] {
    G_IDLE = 3'b001,
    G_DIV  = 3'b010,
    G_MUL  = 3'b100
  } gstate_t;

  gstate_t               state_r;
  logic [31:0]           gain_r;
  logic [QUO_W-1:0]      quo_r;
  logic [14:0]           rem_r;
  logic [14:0]           dsr_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [31:0]           prod_r;

  logic [15:0]           rem_sh;
  logic [15:0]           rem_sub;
  logic                  ge;
  logic [QUO_W-1:0]      quo_nxt;
  logic                  div_pos;
  logic [15:0]           mag;

  // One divider step: shift in the next numerator bit and try to subtract.
  always_comb begin
    rem_sh  = {rem_r, quo_r[QUO_W-1]};
    rem_sub = rem_sh - {1'b0, dsr_r};
    ge      = (rem_sh >= {1'b0, dsr_r});
    quo_nxt = {quo_r[QUO_W-2:0], ge};
    div_pos = !req.divisor[15] && (req.divisor != 16'd0);
    mag     = 16'(-req.divisor);
  end

  // Control and gain registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
      gain_r  <= GAIN_RESET;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        G_IDLE: begin
          if (req.start) begin
            cnt_r   <= '0;
            state_r <= div_pos ? G_DIV : G_MUL;
          end
        end
        G_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DIV_LAST) begin
            gain_r  <= {{(32-QUO_W){1'b0}}, quo_nxt};
            state_r <= G_IDLE;
          end
        end
        G_MUL: begin
          gain_r  <= (|prod_r[31:23]) ? GAIN_MAX : {prod_r[23:0], 8'h00};
          state_r <= G_IDLE;
        end
        default: state_r <= G_IDLE;
      endcase
    end
  end

  // Datapath registers of the divider and the multiplier.
  always_ff @(posedge clk) begin
    if (state_r == G_IDLE && req.start) begin
      quo_r  <= {1'b0, req.volume, 8'h00} + QUO_W'(req.divisor[14:1]);
      rem_r  <= '0;
      dsr_r  <= req.divisor[14:0];
      prod_r <= req.volume * mag;
    end else if (state_r == G_DIV) begin
      quo_r <= quo_nxt;
      rem_r <= ge ? rem_sub[14:0] : rem_sh[14:0];
    end
  end

  assign sts.busy = (state_r != G_IDLE);
  assign sts.gain = gain_r;

endmodule

>>> src/dsdvs_lane.sv
// ----------------------------------------------------------------------------
// dsdvs_lane: one sample scaling lane
// Centers a sample at 128, multiplies it by the gain into a register, then
// divides by 65536 toward zero, clamps and re-biases the result.
// ----------------------------------------------------------------------------
module dsdvs_lane (
  input  logic        clk,
  input  logic        load,
  input  logic [7:0]  sample_in,
  input  logic [31:0] gain,
  output logic [7:0]  scaled
);
  import dsdvs_pkg::*;

  logic signed [40:0] prod_r;
  logic signed [7:0]  centered;
  logic signed [40:0] adj;
  logic signed [24:0] quo;
  logic signed [7:0]  clamped;

  // Sample minus 128 is the sample with its top bit flipped.
  assign centered = {~sample_in[7], sample_in[6:0]};

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= 41'(centered) * $signed({9'b0, gain});
    end
  end

  // Truncating division by 65536 and clamping to the signed byte range.
  always_comb begin
    adj = prod_r + (prod_r[40] ? 41'sd65535 : 41'sd0);
    quo = 25'(adj >>> 16);
    if (quo < -25'sd128) begin
      clamped = -8'sd128;
    end else if (quo > 25'sd127) begin
      clamped = 8'sd127;
    end else begin
      clamped = quo[7:0];
    end
  end

  assign scaled = {~clamped[7], clamped[6:0]};

endmodule

>>> src/dsdvs_merge.sv
// ----------------------------------------------------------------------------
// dsdvs_merge: result merging stage
// Holds the scaled samples that the lanes produced for one item and sends
// them out one result item per cycle while out_stall is low, first lane first.
// ----------------------------------------------------------------------------
module dsdvs_merge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pair_valid,
  input  dsdvs_pkg::pair_t     pair,
  output logic                 pair_ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dsdvs_pkg::out_item_t out_data
);
  import dsdvs_pkg::*;

  pair_t buf_r;
  logic  valid_r;
  logic  idx_r;
  logic  last;
  logic  take;
  logic  load;

  // The result in front is the last of its item when it is lane one's or
  // the item carries a single sample.
  assign last       = !buf_r.two || idx_r;
  assign take       = valid_r && !out_stall;
  assign pair_ready = !valid_r || (take && last);
  assign load       = pair_valid && pair_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= 1'b0;
    end else if (take) begin
      if (last) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= pair;
    end
  end

  assign out_valid           = valid_r;
  assign out_data.sample_out = idx_r ? buf_r.sample1 : buf_r.sample0;
  assign out_data.last_of_run = last;
  assign out_data.sample_end  = last && buf_r.eos;

endmodule

>>> src/dpcm_sample_decode_volume_scale.sv
// ----------------------------------------------------------------------------
// dpcm_sample_decode_volume_scale: PCM / table DPCM decoder with gain
// Decodes stored sample bytes into one or two volume-scaled samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (data byte, start flag, end flag) arrive on in_valid/in_stall.
//   In PCM mode each item yields one result item; in DPCM mode the high and
//   low nibbles are decoded together and two scaling lanes work side by
//   side, then the merge stage sends the two results one after the other.
//   Result items leave on out_valid/out_stall.
//   The first result of an item passes the stage-one registers, the lane
//   product registers and the merge buffer. Rate: one item per cycle in
//   PCM mode while out_stall is low and no gain is derived; in DPCM mode
//   the merge stage takes a new item only as the second result of the last leaves the single output port.
//   Configuration writes use cfg_valid/cfg_ready with cfg_index and
//   cfg_data. A write of volume or divisor derives a new gain: cfg_ready is
//   low and input items are stalled while the gain unit is busy: while
//   the restoring divider runs on a positive divisor, or while the
//   multiplier serves otherwise.
//   A stall on the output holds the result in front; the stages behind fill
//   and then the input stalls too. Reset clears the pipeline, restarts the
//   accumulator at 128 and loads the registers in PCM mode with volume and
//   divisor at 256, which gives a gain of 256.
// ----------------------------------------------------------------------------
module dpcm_sample_decode_volume_scale (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dsdvs_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dsdvs_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [63:0]          cfg_data
);
  import dsdvs_pkg::*;

  // Configuration registers.
  logic        mode_r;
  logic [63:0] tbl_low_r;
  logic [63:0] tbl_high_r;
  logic [15:0] volume_r;
  logic [15:0] divisor_r;
  logic [15:0] volume_nxt;
  logic [15:0] divisor_nxt;
  logic        cfg_wr;

  gain_req_t   greq;
  gain_sts_t   gsts;

  // Decode state and pipeline stages.
  logic [7:0]  acc_r;
  logic [7:0]  acc_base;
  logic [7:0]  s0;
  logic [7:0]  s1;
  logic        in_acc;

  logic        v1_r;
  logic [7:0]  s0_r;
  logic [7:0]  s1_r;
  logic        two1_r;
  logic        eos1_r;

  logic        v2_r;
  logic        two2_r;
  logic        eos2_r;

  logic        st1_ready;
  logic        st2_ready;
  logic        adv2;
  logic        merge_ready;
  pair_t       pair;

  function automatic logic [7:0] delta_of(input logic [127:0] tbl,
                                          input logic [NIB_W-1:0] nib);
    return tbl[{nib, 3'b000} +: 8];
  endfunction

  // Register writes and the gain request that follows a volume or divisor write.
  assign cfg_ready = !gsts.busy;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    volume_nxt  = volume_r;
    divisor_nxt = divisor_r;
    greq.start  = 1'b0;
    if (cfg_wr) begin
      case (cfg_index)
        REG_VOLUME: begin
          volume_nxt = cfg_data[15:0];
          greq.start = 1'b1;
        end
        REG_VOL_DIVISOR: begin
          divisor_nxt = cfg_data[15:0];
          greq.start  = 1'b1;
        end
        default: ;
      endcase
    end
    greq.volume  = volume_nxt;
    greq.divisor = divisor_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 1'b0;
      tbl_low_r  <= '0;
      tbl_high_r <= '0;
      volume_r   <= VOLUME_RESET;
      divisor_r  <= DIV_RESET;
    end else begin
      volume_r  <= volume_nxt;
      divisor_r <= divisor_nxt;
      if (cfg_wr) begin
        case (cfg_index)
          REG_CODING_MODE: mode_r     <= cfg_data[0];
          REG_DELTA_LOW:   tbl_low_r  <= cfg_data;
          REG_DELTA_HIGH:  tbl_high_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  dsdvs_gain u_gain (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (greq),
    .sts   (gsts)
  );

  // Handshake across the stages.
  assign st2_ready = !v2_r || merge_ready;
  assign st1_ready = !v1_r || st2_ready;
  assign adv2      = v1_r && st2_ready;
  assign in_stall  = !st1_ready || gsts.busy;
  assign in_acc    = in_valid && !in_stall;

  // Accumulator steps for both nibbles of the item in DPCM mode; the byte itself in PCM mode.
  always_comb begin
    acc_base = in_data.sample_start ? ACC_INIT : acc_r;
    s0 = mode_r ? acc_base + delta_of({tbl_high_r, tbl_low_r}, in_data.data_byte[7:4])
                : in_data.data_byte;
    s1 = s0 + delta_of({tbl_high_r, tbl_low_r}, in_data.data_byte[3:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= ACC_INIT;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        acc_r <= mode_r ? s1 : acc_base;
      end
      if (in_acc) begin
        v1_r <= 1'b1;
      end else if (adv2) begin
        v1_r <= 1'b0;
      end
      if (adv2) begin
        v2_r <= 1'b1;
      end else if (merge_ready) begin
        v2_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_r   <= s0;
      s1_r   <= s1;
      two1_r <= mode_r;
      eos1_r <= in_data.end_of_sample;
    end
    if (adv2) begin
      two2_r <= two1_r;
      eos2_r <= eos1_r;
    end
  end

  // Two scaling lanes, one per nibble.
  dsdvs_lane u_lane0 (
    .clk       (clk),
    .load      (adv2),
    .sample_in (s0_r),
    .gain      (gsts.gain),
    .scaled    (pair.sample0)
  );

  dsdvs_lane u_lane1 (
    .clk       (clk),
    .load      (adv2),
    .sample_in (s1_r),
    .gain      (gsts.gain),
    .scaled    (pair.sample1)
  );

  assign pair.two = two2_r;
  assign pair.eos = eos2_r;

  dsdvs_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .pair_valid (v2_r),
    .pair       (pair),
    .pair_ready (merge_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
